// ----- src/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, sampled on clk and disabled in reset
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge out of reset
`define ASSERT_ALWAYS(name, cond) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

// trigger at one edge implies the consequence at the next edge
`define ASSERT_NEXT(name, trig, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- src/ddo_pkg.sv -----
// ---------------------------------------------------------------------------
// ddo_pkg
// constants, types and helper functions of the odometry block
// ---------------------------------------------------------------------------
`default_nettype none

package ddo_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int ITER_W       = $clog2(CORDIC_STEPS + 1);

  // shared shift-add multiplier
  localparam int MUL_W     = 64;
  localparam int MUL_B_W   = 32;
  localparam int MUL_CNT_W = $clog2(MUL_B_W + 1);

  // serial modulo of the heading increments
  localparam int MOD_W     = 36;
  localparam int MOD_CNT_W = $clog2(MOD_W + 1);
  localparam int REM_W     = 19;

  localparam int ANG_W  = 19;
  localparam int WRAP_W = 21;
  localparam int CRD_W  = 33;
  localparam int Z_W    = 34;

  localparam logic [MUL_B_W-1:0] DEG_TO_RAD_Q32 = 32'd74961321;
  localparam logic [CRD_W-1:0]   CORDIC_GAIN_Q30 = 33'd652032874;

  localparam logic signed [WRAP_W-1:0] PI_W      = 21'sd205887;
  localparam logic signed [WRAP_W-1:0] TWO_PI_W  = 21'sd411774;
  localparam logic signed [ANG_W-1:0]  PI_A      = 19'sd205887;
  localparam logic signed [ANG_W-1:0]  HALF_PI_A = 19'sd102944;
  localparam logic [REM_W:0]           TWO_PI_R  = 20'd411774;

  localparam logic [15:0] WHEEL_RADIUS_RESET = 16'd1835;
  localparam logic [15:0] INV_BASE_RESET     = 16'd2133;

  typedef enum logic {
    CFG_WHEEL_RADIUS = 1'b0,
    CFG_INV_BASE     = 1'b1
  } cfg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_MOD,
    ST_WRAP,
    ST_MID,
    ST_FOLD,
    ST_ROT,
    ST_MUL4,
    ST_FIN
  } state_t;

  // atan(2^-i) in q2.30
  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [29:0] a;
    case (i)
      5'd0:  a = 30'd843314857;
      5'd1:  a = 30'd497837829;
      5'd2:  a = 30'd263043837;
      5'd3:  a = 30'd133525159;
      5'd4:  a = 30'd67021687;
      5'd5:  a = 30'd33543516;
      5'd6:  a = 30'd16775851;
      5'd7:  a = 30'd8388437;
      5'd8:  a = 30'd4194283;
      5'd9:  a = 30'd2097149;
      5'd10: a = 30'd1048576;
      5'd11: a = 30'd524288;
      5'd12: a = 30'd262144;
      5'd13: a = 30'd131072;
      5'd14: a = 30'd65536;
      5'd15: a = 30'd32768;
      5'd16: a = 30'd16384;
      5'd17: a = 30'd8192;
      5'd18: a = 30'd4096;
      5'd19: a = 30'd2048;
      5'd20: a = 30'd1024;
      5'd21: a = 30'd512;
      5'd22: a = 30'd256;
      5'd23: a = 30'd128;
      default: a = '0;
    endcase
    return a;
  endfunction

  // bring an angle within two turns back to (-pi, pi]
  function automatic logic signed [ANG_W-1:0] wrap_angle(input logic signed [WRAP_W-1:0] v);
    logic signed [WRAP_W-1:0] r;
    r = v;
    if (r >= TWO_PI_W) begin
      r = r - TWO_PI_W;
    end else if (r <= -TWO_PI_W) begin
      r = r + TWO_PI_W;
    end
    if (r > PI_W) begin
      r = r - TWO_PI_W;
    end else if (r <= -PI_W) begin
      r = r + TWO_PI_W;
    end
    return r[ANG_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- src/ddo_intf.sv -----
// ---------------------------------------------------------------------------
// ddo_intf
// valid/ready channels for wheel increments and the resulting pose
// ---------------------------------------------------------------------------
`default_nettype none

interface ddo_wheel_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] right_degrees;
  logic signed [15:0] left_degrees;

  modport source (output valid, right_degrees, left_degrees, input ready);
  modport sink (input valid, right_degrees, left_degrees, output ready);
endinterface

interface ddo_pose_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [18:0] heading;

  modport source (output valid, pos_x, pos_y, heading, input ready);
  modport sink (input valid, pos_x, pos_y, heading, output ready);
endinterface

`default_nettype wire

// ----- src/ddo_mul.sv -----
// ---------------------------------------------------------------------------
// ddo_mul
// two-lane bit-serial shift-add multiplier sharing one multiplier operand
// ---------------------------------------------------------------------------
`default_nettype none

module ddo_mul (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [ddo_pkg::MUL_W-1:0]   a0,
  input  wire logic [ddo_pkg::MUL_W-1:0]   a1,
  input  wire logic [ddo_pkg::MUL_B_W-1:0] b,
  output logic      [ddo_pkg::MUL_W-1:0]   p0,
  output logic      [ddo_pkg::MUL_W-1:0]   p1,
  output logic                           done
);
  import ddo_pkg::*;

  logic [MUL_W-1:0]     ma0;
  logic [MUL_W-1:0]     ma1;
  logic [MUL_W-1:0]     acc0;
  logic [MUL_W-1:0]     acc1;
  logic [MUL_B_W-1:0]   mb;
  logic [MUL_CNT_W-1:0] cnt;
  logic                 busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= MUL_CNT_W'(MUL_B_W);
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt - MUL_CNT_W'(1);
      end
    end
  end

  // one multiplier bit per cycle, lsb first
  always_ff @(posedge clk) begin
    if (start) begin
      ma0  <= a0;
      ma1  <= a1;
      mb   <= b;
      acc0 <= '0;
      acc1 <= '0;
    end else if (busy && cnt != '0) begin
      if (mb[0]) begin
        acc0 <= acc0 + ma0;
        acc1 <= acc1 + ma1;
      end
      ma0 <= ma0 << 1;
      ma1 <= ma1 << 1;
      mb  <= mb >> 1;
    end
  end

  assign p0   = acc0;
  assign p1   = acc1;
  assign done = busy && (cnt == '0);

endmodule

`default_nettype wire

// ----- src/differential_drive_odometry.sv -----
// flow: four passes of the 32-bit serial multiplier, a 36-step serial
// modulo and one CORDIC iteration per cycle make up the work of an item;
// an input is taken only in idle, so a new item waits until the last one
// is through; the last pose may wait
// reset: synchronous, clears the pose to zero and loads the default
// wheel radius and reciprocal wheel base
// ---------------------------------------------------------------------------
// differential_drive_odometry
// dead reckoning pose update of a differential drive from wheel increments
// ---------------------------------------------------------------------------
`default_nettype none

module differential_drive_odometry (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data,
  ddo_wheel_if.sink        wheels,
  ddo_pose_if.source       pose
);
  import ddo_pkg::*;

`include "assert_macros.svh"

  state_t state, state_next;

  logic [15:0] wheel_radius;
  logic [15:0] inverse_wheel_base;

  // multiplier
  logic               mul_start;
  logic [MUL_W-1:0]   mul_a0, mul_a1, mul_p0, mul_p1;
  logic [MUL_B_W-1:0] mul_b;
  logic               mul_done;

  // operands from the input transaction
  logic signed [16:0] wsum, wdiff;
  logic [16:0]        wsum_mag, wdiff_mag;
  logic               sum_neg, diff_neg, ds_neg;
  logic [26:0]        ds_mag;
  logic [MUL_W-1:0]   ds_full, dq_full, inc_full, half_full;

  // serial modulo
  logic [MOD_W-1:0]     num_i, num_h;
  logic [REM_W-1:0]     rem_i, rem_h;
  logic [REM_W:0]       trial_i, trial_h;
  logic [MOD_CNT_W-1:0] mod_cnt;

  logic signed [ANG_W-1:0] inc_w, half_w, mid, head_new, ang;
  logic                    fold_neg;

  // cordic
  logic signed [CRD_W-1:0] cx, cy, xs, ys, c_val, s_val, c_abs, s_abs;
  logic signed [Z_W-1:0]   cz, atan_z;
  logic [ITER_W-1:0]       iter;
  logic                    rot_neg, rot_last, x_neg, y_neg;

  // write back
  logic [MUL_W-1:0]  dx_full, dy_full;
  logic signed [33:0] dx, dy, nx, ny;
  logic signed [31:0] acc_x, acc_y, sx, sy;
  logic signed [ANG_W-1:0] acc_heading;
  logic               out_valid, out_load;
  logic signed [31:0] out_x, out_y;
  logic signed [ANG_W-1:0] out_h;

  ddo_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a0    (mul_a0),
    .a1    (mul_a1),
    .b     (mul_b),
    .p0    (mul_p0),
    .p1    (mul_p1),
    .done  (mul_done)
  );

  assign wsum      = {wheels.right_degrees[15], wheels.right_degrees}
                   + {wheels.left_degrees[15], wheels.left_degrees};
  assign wdiff     = {wheels.right_degrees[15], wheels.right_degrees}
                   - {wheels.left_degrees[15], wheels.left_degrees};
  assign wsum_mag  = wsum[16] ? 17'(-wsum) : 17'(wsum);
  assign wdiff_mag = wdiff[16] ? 17'(-wdiff) : 17'(wdiff);

  // rounding of the magnitudes, halves away from zero
  assign ds_full   = (mul_p0 + (MUL_W'(1) << 32)) >> 33;
  assign dq_full   = (mul_p1 + (MUL_W'(1) << 15)) >> 16;
  assign inc_full  = (mul_p0 + (MUL_W'(1) << 23)) >> 24;
  assign half_full = (mul_p0 + (MUL_W'(1) << 24)) >> 25;
  assign dx_full   = (mul_p0 + (MUL_W'(1) << 29)) >> 30;
  assign dy_full   = (mul_p1 + (MUL_W'(1) << 29)) >> 30;

  assign trial_i = {rem_i, num_i[MOD_W-1]};
  assign trial_h = {rem_h, num_h[MOD_W-1]};

  assign xs       = cx >>> iter;
  assign ys       = cy >>> iter;
  assign atan_z   = Z_W'(atan_q30(5'(iter)));
  assign rot_last = (iter == ITER_W'(CORDIC_STEPS));
  assign c_val    = rot_neg ? -cx : cx;
  assign s_val    = rot_neg ? -cy : cy;
  assign c_abs    = c_val[CRD_W-1] ? -c_val : c_val;
  assign s_abs    = s_val[CRD_W-1] ? -s_val : s_val;

  always_comb begin
    ang      = mid;
    fold_neg = 1'b0;
    if (mid > HALF_PI_A) begin
      ang      = mid - PI_A;
      fold_neg = 1'b1;
    end else if (mid < -HALF_PI_A) begin
      ang      = mid + PI_A;
      fold_neg = 1'b1;
    end
  end

  assign dx = x_neg ? -34'(dx_full[31:0]) : 34'(dx_full[31:0]);
  assign dy = y_neg ? -34'(dy_full[31:0]) : 34'(dy_full[31:0]);
  assign nx = {{2{acc_x[31]}}, acc_x} + dx;
  assign ny = {{2{acc_y[31]}}, acc_y} + dy;

  always_comb begin
    sx = nx[31:0];
    if (nx > 34'sd2147483647) begin
      sx = 32'sh7fffffff;
    end else if (nx < -34'sd2147483648) begin
      sx = 32'sh80000000;
    end
    sy = ny[31:0];
    if (ny > 34'sd2147483647) begin
      sy = 32'sh7fffffff;
    end else if (ny < -34'sd2147483648) begin
      sy = 32'sh80000000;
    end
  end

  assign out_load = (state == ST_FIN) && (!out_valid || pose.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    mul_start     = 1'b0;
    mul_a0        = '0;
    mul_a1        = '0;
    mul_b         = '0;
    wheels.ready  = 1'b0;
    case (state)
      ST_IDLE: begin
        wheels.ready = 1'b1;
        mul_a0       = MUL_W'(wsum_mag);
        mul_a1       = MUL_W'(wdiff_mag);
        mul_b        = MUL_B_W'(wheel_radius);
        if (wheels.valid) begin
          mul_start  = 1'b1;
          state_next = ST_MUL1;
        end
      end
      ST_MUL1: begin
        mul_a0 = mul_p0;
        mul_a1 = mul_p1;
        mul_b  = DEG_TO_RAD_Q32;
        if (mul_done) begin
          mul_start  = 1'b1;
          state_next = ST_MUL2;
        end
      end
      ST_MUL2: begin
        mul_a0 = dq_full;
        mul_b  = MUL_B_W'(inverse_wheel_base);
        if (mul_done) begin
          mul_start  = 1'b1;
          state_next = ST_MUL3;
        end
      end
      ST_MUL3: begin
        if (mul_done) begin
          state_next = ST_MOD;
        end
      end
      ST_MOD: begin
        if (mod_cnt == '0) begin
          state_next = ST_WRAP;
        end
      end
      ST_WRAP: state_next = ST_MID;
      ST_MID:  state_next = ST_FOLD;
      ST_FOLD: state_next = ST_ROT;
      ST_ROT: begin
        mul_a0 = MUL_W'(c_abs);
        mul_a1 = MUL_W'(s_abs);
        mul_b  = MUL_B_W'(ds_mag);
        if (rot_last) begin
          mul_start  = 1'b1;
          state_next = ST_MUL4;
        end
      end
      ST_MUL4: begin
        if (mul_done) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wheel_radius       <= WHEEL_RADIUS_RESET;
      inverse_wheel_base <= INV_BASE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WHEEL_RADIUS: wheel_radius       <= cfg_data;
        CFG_INV_BASE:     inverse_wheel_base <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mod_cnt <= '0;
      iter    <= '0;
    end else begin
      case (state)
        ST_MUL3: begin
          if (mul_done) begin
            mod_cnt <= MOD_CNT_W'(MOD_W);
          end
        end
        ST_MOD: begin
          if (mod_cnt != '0) begin
            mod_cnt <= mod_cnt - MOD_CNT_W'(1);
          end
        end
        ST_FOLD: iter <= '0;
        ST_ROT: begin
          if (!rot_last) begin
            iter <= iter + ITER_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        sum_neg  <= wsum[16];
        diff_neg <= wdiff[16];
      end
      ST_MUL2: begin
        if (mul_done) begin
          ds_mag <= ds_full[26:0];
          ds_neg <= sum_neg;
        end
      end
      ST_MUL3: begin
        if (mul_done) begin
          num_i <= inc_full[MOD_W-1:0];
          num_h <= half_full[MOD_W-1:0];
          rem_i <= '0;
          rem_h <= '0;
        end
      end
      ST_MOD: begin
        // one quotient bit per cycle, only the remainder is kept
        if (mod_cnt != '0) begin
          rem_i <= (trial_i >= TWO_PI_R) ? REM_W'(trial_i - TWO_PI_R) : REM_W'(trial_i);
          rem_h <= (trial_h >= TWO_PI_R) ? REM_W'(trial_h - TWO_PI_R) : REM_W'(trial_h);
          num_i <= num_i << 1;
          num_h <= num_h << 1;
        end
      end
      ST_WRAP: begin
        inc_w  <= wrap_angle(diff_neg ? -WRAP_W'(rem_i) : WRAP_W'(rem_i));
        half_w <= wrap_angle(diff_neg ? -WRAP_W'(rem_h) : WRAP_W'(rem_h));
      end
      ST_MID: begin
        mid      <= wrap_angle({{2{acc_heading[ANG_W-1]}}, acc_heading}
                             + {{2{half_w[ANG_W-1]}}, half_w});
        head_new <= wrap_angle({{2{acc_heading[ANG_W-1]}}, acc_heading}
                             + {{2{inc_w[ANG_W-1]}}, inc_w});
      end
      ST_FOLD: begin
        cx      <= CORDIC_GAIN_Q30;
        cy      <= '0;
        cz      <= {ang[ANG_W-1], ang, 14'd0};
        rot_neg <= fold_neg;
      end
      ST_ROT: begin
        if (rot_last) begin
          x_neg <= ds_neg ^ c_val[CRD_W-1];
          y_neg <= ds_neg ^ s_val[CRD_W-1];
        end else if (!cz[Z_W-1]) begin
          cx <= cx - ys;
          cy <= cy + xs;
          cz <= cz - atan_z;
        end else begin
          cx <= cx + ys;
          cy <= cy - xs;
          cz <= cz + atan_z;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_x       <= '0;
      acc_y       <= '0;
      acc_heading <= '0;
      out_valid   <= 1'b0;
    end else if (out_load) begin
      acc_x       <= sx;
      acc_y       <= sy;
      acc_heading <= head_new;
      out_valid   <= 1'b1;
    end else if (pose.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_x <= sx;
      out_y <= sy;
      out_h <= head_new;
    end
  end

  assign pose.valid   = out_valid;
  assign pose.pos_x   = out_x;
  assign pose.pos_y   = out_y;
  assign pose.heading = out_h;

  `ASSERT_NEXT(a_accept_starts_mul, wheels.valid && wheels.ready, state == ST_MUL1)
  `ASSERT_ALWAYS(a_heading_range, acc_heading <= PI_A && acc_heading > -PI_A)
  `ASSERT_ALWAYS(a_mul_done_in_mul_state, !mul_done || state == ST_MUL1 ||
                 state == ST_MUL2 || state == ST_MUL3 || state == ST_MUL4)
  `ASSERT_NEXT(a_load_returns_idle, out_load, state == ST_IDLE && out_valid)

endmodule

`default_nettype wire

// ----- dv/differential_drive_odometry_test.sv -----
// ---------------------------------------------------------------------------
// differential_drive_odometry_test
// drives wheel increments through the odometry block with random idling on
// both channels and checks every pose against a bit-exact pose predictor
// ---------------------------------------------------------------------------
`default_nettype none

module differential_drive_odometry_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ddo_pkg::*;

  localparam int  WATCHDOG_LIMIT = 4000;
  localparam int  N_RANDOM       = 830;
  localparam logic [63:0] DEG_Q32 = 64'd74961321;
  localparam longint PI_Q16     = 205887;
  localparam longint TWO_PI_Q16 = 411774;
  localparam longint HALF_PI    = 102944;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [18:0] heading;
  } pose_t;

  typedef struct {
    bit                 cfg;       // register write row
    logic               index;
    logic [15:0]        data;
    logic signed [15:0] right;
    logic signed [15:0] left;
    bit                 known;     // expected pose typed in below
    pose_t              pose;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic        cfg_we    = 1'b0;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data  = '0;

  ddo_wheel_if wheels ();
  ddo_pose_if  pose ();

  differential_drive_odometry u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .wheels    (wheels.sink),
    .pose      (pose.source)
  );

  always #2 clk = ~clk;

  // predictor state
  longint radius, inv_base, px, py, hd;
  pose_t  pose_q[$];
  int     errors = 0;
  bit     calm = 1'b0;        // no idling stretch
  int     idle_cycles = 0;
  row_t   rows[$];

  function automatic longint rnd_shift(longint v, int n);
    longint h;
    h = longint'(1) << (n - 1);
    if (v < 0) return -((-v + h) >>> n);
    return (v + h) >>> n;
  endfunction

  function automatic longint floor_sh(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint wrap(longint v);
    longint r;
    r = v % TWO_PI_Q16;
    if (r > PI_Q16) r -= TWO_PI_Q16;
    if (r <= -PI_Q16) r += TWO_PI_Q16;
    return r;
  endfunction

  function automatic longint sat(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint atan_tab(int i);
    longint t[24] = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
                      16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
                      131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
                      256, 128};
    return t[i];
  endfunction

  task automatic rotate(input longint ang, output longint c, output longint s);
    longint x, y, z, xs, ys;
    bit neg;
    x = 652032874; y = 0; neg = 0;
    if (ang > HALF_PI) begin
      ang -= PI_Q16; neg = 1;
    end else if (ang < -HALF_PI) begin
      ang += PI_Q16; neg = 1;
    end
    z = ang * 16384;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = floor_sh(x, i);
      ys = floor_sh(y, i);
      if (z >= 0) begin
        x -= ys; y += xs; z -= atan_tab(i);
      end else begin
        x += ys; y -= xs; z += atan_tab(i);
      end
    end
    c = neg ? -x : x;
    s = neg ? -y : y;
  endtask

  task automatic advance_pose(input logic signed [15:0] dr, input logic signed [15:0] dl,
                              output pose_t p);
    longint r, l, ds, diff, turn, inc, half, mid, c, s, k;
    r = dr; l = dl; k = longint'(DEG_Q32);
    ds   = rnd_shift(radius * (r + l) * k, 33);
    diff = rnd_shift(radius * (r - l) * k, 16);
    turn = diff * inv_base;
    inc  = wrap(rnd_shift(turn, 24));
    half = wrap(rnd_shift(turn, 25));
    mid  = wrap(hd + half);
    rotate(mid, c, s);
    px = sat(px + rnd_shift(ds * c, 30));
    py = sat(py + rnd_shift(ds * s, 30));
    hd = wrap(hd + inc);
    p.pos_x = px[31:0];
    p.pos_y = py[31:0];
    p.heading = hd[18:0];
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // pose sink: random back-pressure and field checks
  always @(posedge clk) begin
    pose_t w;
    if (rst) begin
      pose.ready <= 1'b0;
    end else begin
      if (pose.valid && pose.ready) begin
        if (pose_q.size() == 0) begin
          report("unexpected pose", pose.pos_x, 0);
        end else begin
          w = pose_q.pop_front();
          if (pose.pos_x !== w.pos_x) report("pos_x", pose.pos_x, w.pos_x);
          if (pose.pos_y !== w.pos_y) report("pos_y", pose.pos_y, w.pos_y);
          if (pose.heading !== w.heading)
            report("heading", 32'(pose.heading), 32'(w.heading));
        end
      end
      pose.ready <= calm || ($urandom_range(99) >= 13);
    end
  end

  // watchdog on cycles with no transaction
  always @(posedge clk) begin
    if ((wheels.valid && wheels.ready) || (pose.valid && pose.ready) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("** differential_drive_odometry: FAILED **");
      $finish;
    end
  end

  task automatic write_reg(input logic idx, input logic [15:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == CFG_WHEEL_RADIUS) radius = val; else inv_base = val;
  endtask

  task automatic drain;
    wheels.valid <= 1'b0;
    while (pose_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // valid stays high after a transaction so that items can follow back to back
  task automatic send(input logic signed [15:0] dr, input logic signed [15:0] dl,
                      input bit known, input pose_t want);
    pose_t p;
    while (!calm && $urandom_range(99) < 13) begin
      wheels.valid <= 1'b0;
      @(posedge clk);
    end
    wheels.valid <= 1'b1;
    wheels.right_degrees <= dr;
    wheels.left_degrees <= dl;
    advance_pose(dr, dl, p);
    if (known && p != want) begin
      report("typed pose row", p.pos_x, want.pos_x);
    end
    pose_q.push_back(p);
    do @(posedge clk); while (!wheels.ready);
  endtask

  function automatic row_t mv(int r, int l);
    row_t x;
    x = '{default: 0};
    x.right = 16'(r); x.left = 16'(l);
    return x;
  endfunction

  function automatic row_t wr(logic idx, int v);
    row_t x;
    x = '{default: 0};
    x.cfg = 1; x.index = idx; x.data = 16'(v);
    return x;
  endfunction

  function automatic logic signed [15:0] pick16;
    case ($urandom_range(5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'($urandom_range(64) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    row_t x;
    wheels.valid = 1'b0;
    wheels.right_degrees = '0;
    wheels.left_degrees = '0;
    radius = 1835; inv_base = 2133; px = 0; py = 0; hd = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero increments after reset leave the pose at the origin
    x = mv(0, 0); x.known = 1; x.pose = '{0, 0, 0}; rows.push_back(x);
    rows.push_back(mv(360, 360));
    rows.push_back(mv(-360, -360));
    rows.push_back(mv(32767, -32768));
    rows.push_back(mv(-32768, 32767));
    rows.push_back(mv(32767, 32767));
    rows.push_back(mv(-32768, -32768));
    rows.push_back(mv(90, -90));
    rows.push_back(mv(1, 0));
    rows.push_back(wr(CFG_WHEEL_RADIUS, 65535));
    rows.push_back(wr(CFG_INV_BASE, 65535));
    // large turns wrap the heading several times over
    rows.push_back(mv(32767, -32768));
    rows.push_back(mv(-32768, 32767));
    rows.push_back(mv(12345, -321));
    // repeated full forward moves with the largest wheel radius
    for (int i = 0; i < 4; i++) rows.push_back(mv(32767, 32767));
    rows.push_back(wr(CFG_WHEEL_RADIUS, 0));
    rows.push_back(mv(32767, -32768));
    rows.push_back(wr(CFG_INV_BASE, 0));
    rows.push_back(wr(CFG_WHEEL_RADIUS, 1));
    rows.push_back(mv(-32768, 32767));
    rows.push_back(wr(CFG_INV_BASE, 1));
    rows.push_back(mv(1000, -1000));

    foreach (rows[i]) begin
      if (rows[i].cfg) begin
        drain();
        write_reg(rows[i].index, rows[i].data);
      end else begin
        send(rows[i].right, rows[i].left, rows[i].known, rows[i].pose);
      end
    end

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 100 == 0) begin
        drain();
        case ((n / 100) % 4)
          0: begin
            write_reg(CFG_WHEEL_RADIUS, 16'(1835)); write_reg(CFG_INV_BASE, 16'(2133));
          end
          1: begin
            write_reg(CFG_WHEEL_RADIUS, 16'($urandom)); write_reg(CFG_INV_BASE, 16'($urandom));
          end
          2: begin
            write_reg(CFG_WHEEL_RADIUS, 16'hffff); write_reg(CFG_INV_BASE, 16'd1);
          end
          default: begin
            write_reg(CFG_WHEEL_RADIUS, 16'd1); write_reg(CFG_INV_BASE, 16'hffff);
          end
        endcase
      end
      calm = (n >= 300 && n < 400);
      if (n == 500) begin
        // hold off until every pose is back
        while (pose_q.size() != 0) @(posedge clk);
      end
      send(pick16(), pick16(), 0, '{0, 0, 0});
    end
    calm = 0;

    wheels.valid <= 1'b0;
    while (pose_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("** differential_drive_odometry: PASSED **");
    end else begin
      $display("** differential_drive_odometry: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
